// ===== rtl/core/l2tpv3_encap_decap_assert.svh =====
// ----------------------------------------------------------------------------
// l2tpv3_encap_decap_assert
// Assertion macros shared by the RTL. Each expands to one labeled
// concurrent assertion, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef L2TPV3_ENCAP_DECAP_ASSERT_SVH
`define L2TPV3_ENCAP_DECAP_ASSERT_SVH

// Same-cycle implication.
`define L2TP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define L2TP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/l2tp_pkg.sv =====
// ----------------------------------------------------------------------------
// l2tp_pkg
// Types, codes and helpers shared by the L2TPv3 encapsulation block.
// ----------------------------------------------------------------------------
package l2tp_pkg;

  localparam int unsigned PAD_MAX = 40;
  localparam logic [31:0] DATA_WORD = 32'h0003_0000;

  // Configuration register indexes
  localparam logic [2:0] CFG_ENCAP_MODE   = 3'd0;
  localparam logic [2:0] CFG_COOKIE_MODE  = 3'd1;
  localparam logic [2:0] CFG_COUNTER_MODE = 3'd2;
  localparam logic [2:0] CFG_TX_SESSION   = 3'd3;
  localparam logic [2:0] CFG_RX_SESSION   = 3'd4;
  localparam logic [2:0] CFG_TX_COOKIE    = 3'd5;
  localparam logic [2:0] CFG_RX_COOKIE    = 3'd6;
  localparam logic [2:0] CFG_PAD_LENGTH   = 3'd7;

  // Input item kinds
  localparam logic KIND_TX = 1'b0;
  localparam logic KIND_RX = 1'b1;

  // Header regions
  localparam logic [2:0] RGN_UDP     = 3'd0;
  localparam logic [2:0] RGN_SESSION = 3'd1;
  localparam logic [2:0] RGN_COOKIE  = 3'd2;
  localparam logic [2:0] RGN_COUNTER = 3'd3;
  localparam logic [2:0] RGN_PAD     = 3'd4;

  typedef struct packed {
    logic [1:0]  encap_mode;
    logic [1:0]  cookie_mode;
    logic [1:0]  counter_mode;
    logic [31:0] tx_session_id;
    logic [31:0] rx_session_id;
    logic [63:0] tx_cookie_value;
    logic [63:0] rx_cookie_value;
    logic [5:0]  pad_length;
  } cfg_t;

  typedef struct packed {
    logic [6:0] udp_len;
    logic [6:0] cookie_len;
    logic [6:0] cnt_len;
    logic [6:0] pad_len;
    logic [6:0] ip_skip;
    logic [6:0] hdr_len;
    logic       cookie_wide;
    logic       cnt_incr;
  } layout_t;

  typedef struct packed {
    logic [2:0] region;
    logic [2:0] k;
  } loc_t;

  // Field lengths derived from the registers; a selector of 3 acts as 2.
  function automatic layout_t get_layout(input cfg_t c);
    layout_t l;
    l.udp_len     = (c.encap_mode >= 2'd2) ? 7'd4 : 7'd0;
    l.ip_skip     = (c.encap_mode == 2'd0) ? 7'd20 : 7'd0;
    l.cookie_len  = (c.cookie_mode == 2'd0) ? 7'd0 :
                    ((c.cookie_mode == 2'd1) ? 7'd4 : 7'd8);
    l.cookie_wide = (c.cookie_mode >= 2'd2);
    l.cnt_len     = (c.counter_mode != 2'd0) ? 7'd4 : 7'd0;
    l.cnt_incr    = (c.counter_mode == 2'd1);
    l.pad_len     = (c.pad_length > 6'(PAD_MAX)) ? 7'(PAD_MAX) : {1'b0, c.pad_length};
    l.hdr_len     = l.udp_len + 7'd4 + l.cookie_len + l.cnt_len + l.pad_len;
    return l;
  endfunction

  // Big-endian byte k of a 4-byte (wide low) or 8-byte (wide high) field.
  function automatic logic [7:0] be_byte(input logic [63:0] v, input logic wide,
                                         input logic [2:0] k);
    logic [2:0] sh;
    sh = wide ? (3'd7 - k) : (3'd3 - k);
    return v[{sh, 3'b000} +: 8];
  endfunction

endpackage

// ===== rtl/core/l2tpv3_encap_decap.sv =====
// ----------------------------------------------------------------------------
// l2tpv3_encap_decap
// L2TPv3 data-plane header insertion (transmit) and check/strip (receive).
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall): one byte per transfer with kind
//    (transmit or receive), data_byte and frame_last. Transmit and receive
//    streams keep separate state and may interleave byte by byte.
//  - Output channel (out_valid/out_stall): one result byte per transfer with
//    direction, out_byte, frame_end, dropped and run_end; run_end marks the
//    last result caused by an input byte.
//  - Config port (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//    write registers only while the block is idle.
//  - Path: an input transfer passes the input register, then the output
//    register, before its first result.
//  - Throughput: one byte per cycle while the output does not stall. The
//    first byte of a transmit frame holds the input register while its
//    header bytes are emitted. Receive bytes with no result (header bytes,
//    swallowed payload) retire even while the output stalls.
//  - Reset (rst, synchronous): clears configuration, valid flags, header position,
//    sequence counter, frame state and receive position; no clearing pass.
//  - A stalled output holds its result; the input register then fills and
//    in_stall rises until the output moves again (not for a resultless receive byte).
// ----------------------------------------------------------------------------
`include "l2tpv3_encap_decap_assert.svh"

module l2tpv3_encap_decap (
  input  logic       clk,
  input  logic       rst,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [63:0] cfg_data,
  // input bytes
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] data_byte,
  input  logic       frame_last,
  // result bytes
  output logic       out_valid,
  input  logic       out_stall,
  output logic       direction,
  output logic [7:0] out_byte,
  output logic       frame_end,
  output logic       dropped,
  output logic       run_end
);
  import l2tp_pkg::*;

  // Configuration registers
  cfg_t    cfg;
  layout_t lay;

  // Stream state
  logic        tx_in_frame;
  logic [31:0] tx_sequence;
  logic [6:0]  rx_position;
  logic        rx_header_ok;

  // Input register holding the byte being worked on
  logic       pend_valid;
  logic       pend_kind;
  logic [7:0] pend_byte;
  logic       pend_last;
  logic [5:0] hdr_pos;

  // Handshake
  logic advance, pend_done, in_accept;

  // Transmit path
  loc_t       tx_loc;
  logic       tx_hdr_phase;
  logic [7:0] tx_hdr_byte;
  logic [31:0] tx_cnt;

  // Receive path
  loc_t       rx_loc;
  logic [6:0] rx_hl, rx_offs;
  logic       rx_in_hdr, rx_mismatch, rx_emit;

  // Result of the current cycle
  logic       res_emit, res_dir, res_fe, res_drop, res_run_end;
  logic [7:0] res_byte;

  // Terms checked by the assertions
  logic chk_drop_shape, chk_mid_shape, chk_hdr_step;

  assign cfg_ready = 1'b1;
  assign lay       = get_layout(cfg);

  // Write the addressed register; out-of-range bits are masked.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENCAP_MODE:   cfg.encap_mode      <= cfg_data[1:0];
        CFG_COOKIE_MODE:  cfg.cookie_mode     <= cfg_data[1:0];
        CFG_COUNTER_MODE: cfg.counter_mode    <= cfg_data[1:0];
        CFG_TX_SESSION:   cfg.tx_session_id   <= cfg_data[31:0];
        CFG_RX_SESSION:   cfg.rx_session_id   <= cfg_data[31:0];
        CFG_TX_COOKIE:    cfg.tx_cookie_value <= cfg_data;
        CFG_RX_COOKIE:    cfg.rx_cookie_value <= cfg_data;
        CFG_PAD_LENGTH:   cfg.pad_length      <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Transmit: one header byte per cycle unless the output stalls.
  assign tx_hdr_phase = !tx_in_frame && ({1'b0, hdr_pos} < lay.hdr_len);

  l2tp_locate u_tx_locate (
    .lay  (lay),
    .offs ({1'b0, hdr_pos}),
    .loc  (tx_loc)
  );

  // The sequence is pre-incremented on the first header byte, so counter
  // bytes (always past the session) already see the new value.
  assign tx_cnt = lay.cnt_incr ? tx_sequence : 32'd0;

  always_comb begin
    case (tx_loc.region)
      RGN_UDP:     tx_hdr_byte = be_byte({32'd0, DATA_WORD}, 1'b0, tx_loc.k);
      RGN_SESSION: tx_hdr_byte = be_byte({32'd0, cfg.tx_session_id}, 1'b0, tx_loc.k);
      RGN_COOKIE:  tx_hdr_byte = lay.cookie_wide ?
                                 be_byte(cfg.tx_cookie_value, 1'b1, tx_loc.k) :
                                 be_byte({32'd0, cfg.tx_cookie_value[31:0]}, 1'b0,
                                         tx_loc.k);
      RGN_COUNTER: tx_hdr_byte = be_byte({32'd0, tx_cnt}, 1'b0, tx_loc.k);
      default:     tx_hdr_byte = 8'd0;
    endcase
  end

  // ---------------- receive: check header bytes, pass payload ----------------
  assign rx_hl     = lay.ip_skip + lay.hdr_len;
  assign rx_in_hdr = rx_position < rx_hl;
  assign rx_offs   = rx_position - lay.ip_skip;

  l2tp_locate u_rx_locate (
    .lay  (lay),
    .offs (rx_offs),
    .loc  (rx_loc)
  );

  always_comb begin
    rx_mismatch = 1'b0;
    if (rx_position >= lay.ip_skip) begin
      case (rx_loc.region)
        RGN_SESSION: rx_mismatch = pend_byte !=
                                   be_byte({32'd0, cfg.rx_session_id}, 1'b0, rx_loc.k);
        RGN_COOKIE: begin
          // A 32-bit cookie compares zero-extended against the 64-bit value.
          rx_mismatch = (pend_byte != be_byte(cfg.rx_cookie_value, lay.cookie_wide,
                                              rx_loc.k)) ||
                        (!lay.cookie_wide && (cfg.rx_cookie_value[63:32] != 32'd0));
        end
        default: rx_mismatch = 1'b0;
      endcase
    end
  end

  assign rx_emit = (rx_in_hdr || !rx_header_ok) ? pend_last : 1'b1;

  // ---------------- result selection ----------------
  always_comb begin
    if (pend_kind == KIND_TX) begin
      res_emit    = 1'b1;
      res_dir     = 1'b1;
      res_byte    = tx_hdr_phase ? tx_hdr_byte : pend_byte;
      res_fe      = tx_hdr_phase ? 1'b0 : pend_last;
      res_drop    = 1'b0;
      res_run_end = !tx_hdr_phase;
    end else begin
      res_emit    = rx_emit;
      res_dir     = 1'b0;
      res_run_end = 1'b1;
      if (rx_in_hdr || !rx_header_ok) begin
        // drop marker
        res_byte = 8'd0;
        res_fe   = 1'b1;
        res_drop = 1'b1;
      end else begin
        res_byte = pend_byte;
        res_fe   = pend_last;
        res_drop = 1'b0;
      end
    end
  end

  // ---------------- handshake ----------------
  // The output register takes a new result when empty or being drained.
  assign advance   = !out_valid || !out_stall;
  assign pend_done = pend_valid &&
                     ((pend_kind == KIND_TX) ? (advance && !tx_hdr_phase) :
                      (rx_emit ? advance : 1'b1));
  assign in_stall  = pend_valid && !pend_done;
  assign in_accept = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_accept) begin
      pend_valid <= 1'b1;
    end else if (pend_done) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend_kind <= kind;
      pend_byte <= data_byte;
      pend_last <= frame_last;
    end
  end

  // Transmit state: advance the header position, bump the sequence on the
  // first header byte, track frame boundaries on the payload byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_in_frame <= 1'b0;
      tx_sequence <= 32'd0;
      hdr_pos     <= 6'd0;
    end else if (pend_valid && (pend_kind == KIND_TX) && advance) begin
      if (tx_hdr_phase) begin
        hdr_pos <= hdr_pos + 6'd1;
        if ((hdr_pos == 6'd0) && lay.cnt_incr) begin
          tx_sequence <= tx_sequence + 32'd1;
        end
      end else begin
        hdr_pos     <= 6'd0;
        tx_in_frame <= !pend_last;
      end
    end
  end

  // Receive state: one step per retired receive header byte; a frame's last byte resets it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_position  <= 7'd0;
      rx_header_ok <= 1'b1;
    end else if (pend_done && (pend_kind == KIND_RX)) begin
      if (pend_last) begin
        rx_position  <= 7'd0;
        rx_header_ok <= 1'b1;
      end else if (rx_in_hdr) begin
        rx_position <= rx_position + 7'd1;
        if (rx_mismatch) begin
          rx_header_ok <= 1'b0;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= pend_valid && res_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      direction <= res_dir;
      out_byte  <= res_byte;
      frame_end <= res_fe;
      dropped   <= res_drop;
      run_end   <= res_run_end;
    end
  end

  // ---------------- assertions ----------------
  assign chk_drop_shape = frame_end && !direction && (out_byte == 8'd0) && run_end;
  assign chk_mid_shape  = direction && !frame_end;
  assign chk_hdr_step   = pend_valid && (pend_kind == KIND_TX) && tx_hdr_phase && advance;

  `L2TP_ASSERT_NOW(a_drop_marker, out_valid && dropped, chk_drop_shape, "malformed drop marker")
  `L2TP_ASSERT_NOW(a_multi_tx_only, out_valid && !run_end, chk_mid_shape, "bad mid result")
  `L2TP_ASSERT_NEXT(a_hdr_emit, chk_hdr_step, out_valid && direction && !run_end, "no header byte")

endmodule

// ===== rtl/core/l2tp_locate.sv =====
// ----------------------------------------------------------------------------
// l2tp_locate
// Map a header offset to its region and the byte index inside that region.
// ----------------------------------------------------------------------------
module l2tp_locate (
  input  l2tp_pkg::layout_t lay,
  input  logic [6:0]        offs,
  output l2tp_pkg::loc_t    loc
);
  import l2tp_pkg::*;

  logic [6:0] b_sess, b_cookie, b_cnt, b_pad, diff;

  assign b_sess   = lay.udp_len;
  assign b_cookie = b_sess + 7'd4;
  assign b_cnt    = b_cookie + lay.cookie_len;
  assign b_pad    = b_cnt + lay.cnt_len;

  always_comb begin
    loc.region = RGN_PAD;
    diff       = 7'd0;
    if (offs < b_sess) begin
      loc.region = RGN_UDP;
      diff       = offs;
    end else if (offs < b_cookie) begin
      loc.region = RGN_SESSION;
      diff       = offs - b_sess;
    end else if (offs < b_cnt) begin
      loc.region = RGN_COOKIE;
      diff       = offs - b_cookie;
    end else if (offs < b_pad) begin
      loc.region = RGN_COUNTER;
      diff       = offs - b_cnt;
    end
    loc.k = diff[2:0];
  end

endmodule
